/* rtl/core/vdi_pkg.sv */
// vertex dedup indexer package: sizes, coordinate compare, control types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vdi_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W     = 64;
  localparam int INDEX_W     = 11;

  localparam logic [COORD_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
  localparam logic [COORD_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [COORD_W-1:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DELIVER
  } vdi_state_t;

  typedef struct packed {
    logic accept;   // latch incoming vertex, start search
    logic step;     // issue next table read, compare previous
    logic hit;      // record match result
    logic miss;     // append or flag overflow
    logic deliver;  // move result into output register
  } vdi_cmd_t;

  typedef struct packed {
    logic more;      // entries left to read
    logic match;     // entry read last cycle equals vertex
    logic out_free;  // output register can take a word
  } vdi_status_t;

  function automatic logic is_nan(input logic [COORD_W-1:0] a);
    return ((a & EXP_MASK) == EXP_MASK) && ((a & FRAC_MASK) != '0);
  endfunction

  // ieee equality on raw double bits: signed zeros equal, nan never equal
  function automatic logic coord_eq(input logic [COORD_W-1:0] a,
                                    input logic [COORD_W-1:0] b);
    logic both_zero;
    both_zero = ((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0);
    return !is_nan(a) && !is_nan(b) && (both_zero || (a == b));
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vdi_if.sv */
// vertex dedup indexer channel interfaces: vertex words in, index words out
// depends on vdi_pkg
`timescale 1ns / 1ps
`default_nettype none

interface vdi_in_if;
  import vdi_pkg::*;

  logic               valid;
  logic               ready;
  logic               start_new_mesh;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;

  modport source (output valid, start_new_mesh, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, start_new_mesh, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface vdi_out_if;
  import vdi_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] vertex_index;
  logic               is_new;
  logic               overflow;

  modport source (output valid, vertex_index, is_new, overflow, input ready);
  modport sink (input valid, vertex_index, is_new, overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/vdi_ctrl.sv */
// vertex dedup indexer controller: idle / search / deliver sequencing
// depends on vdi_pkg
`timescale 1ns / 1ps
`default_nettype none

module vdi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vdi_pkg::vdi_status_t status,
  output vdi_pkg::vdi_cmd_t    cmd
);
  import vdi_pkg::*;

  vdi_state_t state;
  vdi_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        priority if (status.match) begin
          cmd.hit    = 1'b1;
          state_next = ST_DELIVER;
        end else if (!status.more) begin
          // last entry compared without a match, or the table is empty
          cmd.miss   = 1'b1;
          state_next = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (status.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/vdi_datapath.sv */
// vertex dedup indexer datapath: unique vertex table, search pointer,
// coordinate compare and output register; depends on vdi_pkg, vdi_if
`timescale 1ns / 1ps
`default_nettype none

module vdi_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  vdi_pkg::vdi_cmd_t         cmd,
  output vdi_pkg::vdi_status_t      status,
  input  logic                      start_new_mesh,
  input  logic [vdi_pkg::COORD_W-1:0] coord_x,
  input  logic [vdi_pkg::COORD_W-1:0] coord_y,
  input  logic [vdi_pkg::COORD_W-1:0] coord_z,
  vdi_out_if.source                 result
);
  import vdi_pkg::*;

  logic [COORD_W-1:0] mem_x [TABLE_DEPTH];
  logic [COORD_W-1:0] mem_y [TABLE_DEPTH];
  logic [COORD_W-1:0] mem_z [TABLE_DEPTH];

  logic [COORD_W-1:0] vx, vy, vz;
  logic [COORD_W-1:0] rd_x, rd_y, rd_z;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] rd_ptr;
  logic [COUNT_W-1:0] rd_idx;
  logic               rd_vld;
  logic [INDEX_W-1:0] res_index;
  logic               res_new;
  logic               res_ovf;
  logic               issue;
  logic               full;
  logic               append;

  assign issue  = cmd.step && (rd_ptr != count);
  assign full   = (count == COUNT_W'(TABLE_DEPTH));
  assign append = cmd.miss && !full;

  assign status.more     = (rd_ptr != count);
  assign status.match    = rd_vld && coord_eq(vx, rd_x) && coord_eq(vy, rd_y)
                           && coord_eq(vz, rd_z);
  assign status.out_free = !result.valid || result.ready;

  // table storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (append) begin
      mem_x[count[ADDR_W-1:0]] <= vx;
      mem_y[count[ADDR_W-1:0]] <= vy;
      mem_z[count[ADDR_W-1:0]] <= vz;
    end
    if (issue) begin
      rd_x <= mem_x[rd_ptr[ADDR_W-1:0]];
      rd_y <= mem_y[rd_ptr[ADDR_W-1:0]];
      rd_z <= mem_z[rd_ptr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vx <= coord_x;
      vy <= coord_y;
      vz <= coord_z;
    end
    if (issue) begin
      rd_idx <= rd_ptr;
    end
    if (cmd.hit) begin
      res_index <= INDEX_W'(rd_idx + COUNT_W'(1));
      res_new   <= 1'b0;
      res_ovf   <= 1'b0;
    end else if (cmd.miss) begin
      res_index <= full ? '0 : INDEX_W'(count + COUNT_W'(1));
      res_new   <= !full;
      res_ovf   <= full;
    end
    if (cmd.deliver) begin
      result.vertex_index <= res_index;
      result.is_new       <= res_new;
      result.overflow     <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      rd_ptr       <= '0;
      rd_vld       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rd_ptr <= '0;
        rd_vld <= 1'b0;
        if (start_new_mesh) begin
          count <= '0;
        end
      end else begin
        if (cmd.step) begin
          rd_vld <= issue;
        end
        if (issue) begin
          rd_ptr <= rd_ptr + COUNT_W'(1);
        end
        if (append) begin
          count <= count + COUNT_W'(1);
        end
      end
      if (cmd.deliver) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vertex_dedup_indexer.sv */
// vertex_dedup_indexer: exact-match vertex deduplication against a table of
// up to 1024 unique vertices kept in insertion order.
// channels: vertex (sink) carries start_new_mesh and three ieee double
// coordinate patterns; result (source) carries vertex_index, is_new and
// overflow. each accepted vertex gives exactly one result word.
// the table is searched one entry per cycle through a registered memory
// read port: each entry read is compared against the vertex, a hit or the
// end of the table loads the result register, and the next vertex is taken
// only once that result is delivered and the controller is back in idle.
// a match ends the search early.
// start_new_mesh empties the table before its own vertex is searched.
// reset empties the table and drops any pending result; no clearing pass.
// a result waits in the output register while the receiver stalls; the
// next vertex is still accepted and searched, and only its delivery waits.
// depends on vdi_pkg, vdi_if, vdi_ctrl, vdi_datapath
`timescale 1ns / 1ps
`default_nettype none

module vertex_dedup_indexer (
  input  logic     clk,
  input  logic     rst,
  vdi_in_if.sink   vertex,
  vdi_out_if.source result
);
  import vdi_pkg::*;

  vdi_cmd_t    cmd;
  vdi_status_t status;
  logic        in_ready;

  assign vertex.ready = in_ready;

  vdi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vertex.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vdi_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .start_new_mesh (vertex.start_new_mesh),
    .coord_x        (vertex.coord_x),
    .coord_y        (vertex.coord_y),
    .coord_z        (vertex.coord_z),
    .result         (result)
  );

`ifndef SYNTHESIS
  // a new result word appears only through a deliver command
  a_valid_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.deliver))
    else $error("result valid rose without deliver");

  // overflow words carry index zero and are never marked new
  a_overflow_index: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.overflow) |-> (result.vertex_index == '0 && !result.is_new))
    else $error("overflow word with nonzero index or new flag");

  // one vertex at a time: after an accept the input closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (vertex.valid && vertex.ready) |=> !vertex.ready)
    else $error("vertex accepted while a search was starting");

  // hit and miss are never commanded together
  a_hit_miss_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.hit && cmd.miss))
    else $error("hit and miss in the same cycle");
`endif

endmodule

`default_nettype wire
